>>> rtl/core/approx_vector_normalize_unit_macros.svh
// ----------------------------------------------------------------------------
// approx vector normalize unit assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef APPROX_VECTOR_NORMALIZE_UNIT_MACROS_SVH
`define APPROX_VECTOR_NORMALIZE_UNIT_MACROS_SVH

// same-cycle implication
`define AVNU_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequence a fixed number of cycles later
`define AVNU_ASSERT_DELAY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/avnu_pkg.sv
// ----------------------------------------------------------------------------
// avnu package
// types and constants of the approximate vector normaliser
// ----------------------------------------------------------------------------
package avnu_pkg;

  localparam int COMP_W   = 16;
  localparam int OUT_FRAC = 13;
  localparam int MAG_W    = COMP_W + 1;
  localparam int PROD_W   = MAG_W + 16;
  localparam int LEN_W    = MAG_W + 18;
  localparam int REM_W    = LEN_W + 1;
  // integer part of mag/len is below two, so one integer bit plus a round bit
  localparam int Q_W      = OUT_FRAC + 2;
  localparam int NUM_CELLS = Q_W;
  localparam int SAT_W    = (Q_W > 17) ? Q_W : 17;
  localparam int LATENCY  = 3 + NUM_CELLS + 1;

  localparam logic [15:0] COEF_HI = 16'd55050;
  localparam logic [15:0] COEF_MD = 16'd33915;
  localparam logic [15:0] COEF_LO = 16'd17531;

  typedef struct packed {
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               zero_length;
  } out_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [LEN_W-1:0] len;
    lane_t [2:0]      lane;
  } cell_t;

endpackage

>>> rtl/core/avnu_front.sv
// ----------------------------------------------------------------------------
// avnu front end
// magnitudes, ranking, coefficient products and length estimate
// ----------------------------------------------------------------------------
module avnu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  avnu_pkg::in_t  comp,
  output avnu_pkg::cell_t head
);

  logic [avnu_pkg::COMP_W-1:0] raw [3];
  logic [avnu_pkg::MAG_W-1:0]  mag_c [3];
  logic                        neg_c [3];
  logic [avnu_pkg::MAG_W-1:0]  s_hi, s_md, s_lo, t0_hi, t0_md, t1_md, t1_lo;

  // stage one
  logic                        v1;
  logic [avnu_pkg::MAG_W-1:0]  mag1 [3];
  logic                        neg1 [3];
  logic [avnu_pkg::MAG_W-1:0]  hi1, md1, lo1;
  // stage two
  logic                        v2;
  logic [avnu_pkg::MAG_W-1:0]  mag2 [3];
  logic                        neg2 [3];
  logic [avnu_pkg::PROD_W-1:0] p_hi, p_md, p_lo;
  logic [avnu_pkg::LEN_W-1:0]  len_c;

  assign raw[0] = comp.comp_x[avnu_pkg::COMP_W-1:0];
  assign raw[1] = comp.comp_y[avnu_pkg::COMP_W-1:0];
  assign raw[2] = comp.comp_z[avnu_pkg::COMP_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = raw[i][avnu_pkg::COMP_W-1];
      mag_c[i] = neg_c[i] ? ((avnu_pkg::MAG_W'(1) << avnu_pkg::COMP_W)
                             - {1'b0, raw[i]}) : {1'b0, raw[i]};
    end
  end

  // three compare-swaps
  always_comb begin
    t0_hi = (mag_c[0] < mag_c[1]) ? mag_c[1] : mag_c[0];
    t0_md = (mag_c[0] < mag_c[1]) ? mag_c[0] : mag_c[1];
    t1_md = (t0_md < mag_c[2]) ? mag_c[2] : t0_md;
    t1_lo = (t0_md < mag_c[2]) ? t0_md : mag_c[2];
    s_hi  = (t0_hi < t1_md) ? t1_md : t0_hi;
    s_md  = (t0_hi < t1_md) ? t0_hi : t1_md;
    s_lo  = t1_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      v1      <= take;
      v2      <= v1;
    end
  end

  assign len_c = avnu_pkg::LEN_W'(p_hi) + avnu_pkg::LEN_W'(p_md) + avnu_pkg::LEN_W'(p_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= v2;
    end
    for (int i = 0; i < 3; i++) begin
      mag1[i] <= mag_c[i];
      neg1[i] <= neg_c[i];
      mag2[i] <= mag1[i];
      neg2[i] <= neg1[i];
      head.lane[i].rem <= avnu_pkg::REM_W'(mag2[i]) << 16;
      head.lane[i].quo <= '0;
      head.lane[i].neg <= neg2[i];
    end
    hi1 <= s_hi;
    md1 <= s_md;
    lo1 <= s_lo;
    p_hi <= avnu_pkg::PROD_W'(hi1) * avnu_pkg::PROD_W'(avnu_pkg::COEF_HI);
    p_md <= avnu_pkg::PROD_W'(md1) * avnu_pkg::PROD_W'(avnu_pkg::COEF_MD);
    p_lo <= avnu_pkg::PROD_W'(lo1) * avnu_pkg::PROD_W'(avnu_pkg::COEF_LO);
    head.len  <= len_c;
    head.zero <= (len_c == '0);
  end

endmodule

>>> rtl/core/avnu_cell.sv
// ----------------------------------------------------------------------------
// avnu divider cell
// one restoring division step for all three lanes, registered
// ----------------------------------------------------------------------------
module avnu_cell (
  input  logic            clk,
  input  logic            rst,
  input  avnu_pkg::cell_t din,
  output avnu_pkg::cell_t dout
);

  logic                       ge   [3];
  logic [avnu_pkg::REM_W-1:0] diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ge[i]   = din.lane[i].rem >= avnu_pkg::REM_W'(din.len);
      diff[i] = ge[i] ? din.lane[i].rem - avnu_pkg::REM_W'(din.len) : din.lane[i].rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.zero <= din.zero;
    dout.len  <= din.len;
    for (int i = 0; i < 3; i++) begin
      // remainder is below len here, so the shift cannot overflow
      dout.lane[i].rem <= {diff[i][avnu_pkg::REM_W-2:0], 1'b0};
      dout.lane[i].quo <= {din.lane[i].quo[avnu_pkg::Q_W-2:0], ge[i]};
      dout.lane[i].neg <= din.lane[i].neg;
    end
  end

endmodule

>>> rtl/core/approx_vector_normalize_unit.sv
// ----------------------------------------------------------------------------
// approx vector normalize unit
// scales a 3d vector by an alpha-max-beta-min length estimate
// ----------------------------------------------------------------------------
// usage
//   input: drive comp (x, y, z, signed) with start high; a transfer happens
//   at each rising edge with start high and busy low. busy is always low,
//   so one vector can be taken every cycle.
//   output: result (norm_x/y/z as signed q2.13, zero_length) is shown for
//   exactly one cycle with done high; there is no back-pressure, the
//   receiver must take it in that cycle.
// pipeline: from the transfer edge to the done cycle a vector passes
//   three front stages (magnitude and ranking, coefficient products, length
//   sum), one divider cell per quotient bit (15 of them), and the rounding
//   register.
// throughput: one vector per cycle, set by the divider chain where each
//   cell retires one quotient bit for all three lanes every cycle.
// reset: rst clears every valid bit of the pipeline; data in flight is
//   dropped and no done is raised for it.
// a zero vector yields zero outputs with zero_length set.
// ----------------------------------------------------------------------------
`include "approx_vector_normalize_unit_macros.svh"

module approx_vector_normalize_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  avnu_pkg::in_t   comp,
  output logic            done,
  output avnu_pkg::out_t  result
);

  // chain of divider cells, link 0 fed by the front end
  avnu_pkg::cell_t link [avnu_pkg::NUM_CELLS+1];

  logic [avnu_pkg::Q_W:0]     q_inc [3];
  logic [avnu_pkg::SAT_W-1:0] mag_r [3];
  logic [15:0]                val   [3];
  avnu_pkg::cell_t            tail;

  // fully pipelined, never holds off a transfer
  assign busy = 1'b0;

  avnu_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (start && !busy),
    .comp (comp),
    .head (link[0])
  );

  for (genvar g = 0; g < avnu_pkg::NUM_CELLS; g++) begin : g_cell
    avnu_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (link[g]),
      .dout (link[g+1])
    );
  end

  assign tail = link[avnu_pkg::NUM_CELLS];

  // round half up on the extra bit, then saturate to 16 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_inc[i] = {1'b0, tail.lane[i].quo} + (avnu_pkg::Q_W+1)'(1);
      mag_r[i] = avnu_pkg::SAT_W'(q_inc[i][avnu_pkg::Q_W:1]);
      if (tail.lane[i].neg) begin
        if (mag_r[i] > avnu_pkg::SAT_W'(32768)) begin
          val[i] = 16'h8000;
        end else begin
          val[i] = 16'(avnu_pkg::SAT_W'(65536) - mag_r[i]);
        end
      end else begin
        if (mag_r[i] > avnu_pkg::SAT_W'(32767)) begin
          val[i] = 16'h7fff;
        end else begin
          val[i] = mag_r[i][15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.zero_length <= tail.zero;
    result.norm_x      <= tail.zero ? '0 : val[0];
    result.norm_y      <= tail.zero ? '0 : val[1];
    result.norm_z      <= tail.zero ? '0 : val[2];
  end

  // every accepted vector comes out after the fixed latency
  `AVNU_ASSERT_DELAY(a_latency, start && !busy, 19, done)
  // zero length forces zero components
  `AVNU_ASSERT_IMPLY(a_zero_out, done && result.zero_length,
    result.norm_x == 0 && result.norm_y == 0 && result.norm_z == 0)
  // zero flag matches a zero vector taken earlier
  `AVNU_ASSERT_IMPLY(a_zero_src, done, result.zero_length ==
    $past(comp.comp_x == 0 && comp.comp_y == 0 && comp.comp_z == 0, 19))
  // a nonzero vector has a positive length estimate at the chain head
  `AVNU_ASSERT_IMPLY(a_len_pos, link[0].valid && !link[0].zero, link[0].len != 0)

endmodule
